### rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion with reset disable.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

### rtl/sha256_pkg.sv
// SHA-256 package: sequencer states, round constants, initial hash values
// and the round helper functions. No dependencies.
`default_nettype none
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_ADDH,
    ST_PAD,
    ST_OUT
  } state_e;

  typedef logic [31:0] word_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LAST_RND = 6'd63;
  localparam logic [2:0] LAST_IDX = 3'd7;

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t big_s0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_s1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_s0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_s1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage
`default_nettype wire

### rtl/sha256_stream_hasher_top.sv
// SHA-256 stream hasher: byte intake, padding, round sequencer and digest output.
// Depends on sha256_pkg.
//
// Bytes enter one per accepted item with byte_valid_i set into a 512-bit block
// shift register that doubles as the 16-word message schedule window. One round
// unit runs the 64 rounds of a block, one round a cycle, then folds the result
// into the chain words in ST_ADDH; in_ready_o is low meanwhile. A byte that
// does not fill a block leaves in_ready_o high for the next item. Finishing a
// message shifts in padding one byte a cycle (with a second pad block when the
// length does not fit), runs one or two compressions, one more with double
// hashing, then presents the eight digest words, one per accepted result item.
// The double_hash register is sampled at message end.
`default_nettype none
module sha256_stream_hasher_top
  import sha256_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [7:0]  data_byte_i,
  input  wire         byte_valid_i,
  input  wire         end_of_message_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  state_e       state_q, state_d;
  logic         dbl_cfg_q;
  word_t        h_q [8];
  word_t        v_q [8];
  logic [511:0] buf_q;
  logic [5:0]   fill_q;
  logic [5:0]   rnd_q;
  logic [63:0]  bits_q;
  logic [2:0]   idx_q;
  logic         fin_q, padst_q, lenblk_q, dbl_q, dbl_sel_q;

  // control decoded by the sequencer
  logic         in_acc, out_acc, shift_en, start_comp, load_dbl, clear_msg;
  logic         pad_len_now;
  logic [7:0]   shift_byte;

  assign pready = 1'b1;
  assign prdata = {31'd0, dbl_cfg_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbl_cfg_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr == 3'd0) begin
      dbl_cfg_q <= pwdata[0];
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign in_acc        = in_valid_i && in_ready_o;
  assign out_acc       = out_valid_o && out_ready_i;
  assign digest_word_o = h_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == LAST_IDX);

  assign pad_len_now = lenblk_q && (fill_q >= LEN_POS);

  // round unit
  word_t w0, w_new, t1, t2, ch, maj;
  assign w0    = buf_q[511:480];
  assign w_new = small_s1(buf_q[63:32]) + buf_q[223:192] + small_s0(buf_q[479:448]) + w0;
  assign ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1    = v_q[7] + big_s1(v_q[4]) + ch + ROUND_K[rnd_q] + w0;
  assign t2    = big_s0(v_q[0]) + maj;

  always_comb begin
    state_d    = state_q;
    shift_en   = 1'b0;
    shift_byte = data_byte_i;
    start_comp = 1'b0;
    load_dbl   = 1'b0;
    clear_msg  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          shift_en = byte_valid_i;
          if (byte_valid_i && fill_q == LAST_POS) begin
            start_comp = 1'b1;
            state_d    = ST_COMP;
          end else if (end_of_message_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_COMP: begin
        if (rnd_q == LAST_RND) begin
          state_d = ST_ADDH;
        end
      end
      ST_ADDH: begin
        priority if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (!lenblk_q) begin
          state_d = ST_PAD;
        end else if (dbl_sel_q && !dbl_q) begin
          load_dbl   = 1'b1;
          start_comp = 1'b1;
          state_d    = ST_COMP;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_PAD: begin
        shift_en = 1'b1;
        priority if (!padst_q) begin
          shift_byte = PAD_BYTE;
        end else if (pad_len_now) begin
          shift_byte = bits_q[63:56];
        end else begin
          shift_byte = 8'd0;
        end
        if (fill_q == LAST_POS) begin
          start_comp = 1'b1;
          state_d    = ST_COMP;
        end
      end
      ST_OUT: begin
        if (out_acc && idx_q == LAST_IDX) begin
          clear_msg = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      rnd_q     <= '0;
      bits_q    <= '0;
      idx_q     <= '0;
      fin_q     <= 1'b0;
      padst_q   <= 1'b0;
      lenblk_q  <= 1'b0;
      dbl_q     <= 1'b0;
      dbl_sel_q <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
    end else begin
      if (shift_en) begin
        fill_q <= fill_q + 6'd1;
      end
      if (in_acc) begin
        fin_q     <= end_of_message_i;
        dbl_sel_q <= dbl_cfg_q;
        if (byte_valid_i) bits_q <= bits_q + 64'd8;
      end
      if (state_q == ST_PAD) begin
        if (!padst_q) begin
          padst_q <= 1'b1;
          if (fill_q < LEN_POS) lenblk_q <= 1'b1;
        end else if (pad_len_now) begin
          bits_q <= {bits_q[55:0], 8'd0};
        end
      end
      if (state_q == ST_ADDH && fin_q && padst_q && !lenblk_q) begin
        lenblk_q <= 1'b1;
      end
      if (start_comp) rnd_q <= '0;
      else if (state_q == ST_COMP) rnd_q <= rnd_q + 6'd1;
      if (state_q == ST_ADDH) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (load_dbl) begin
        dbl_q <= 1'b1;
        for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
      end
      if (out_acc) idx_q <= idx_q + 3'd1;
      if (clear_msg) begin
        fill_q   <= '0;
        bits_q   <= '0;
        idx_q    <= '0;
        fin_q    <= 1'b0;
        padst_q  <= 1'b0;
        lenblk_q <= 1'b0;
        dbl_q    <= 1'b0;
        for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
      end
    end
  end

  // block buffer and working variables
  always_ff @(posedge clk_i) begin
    if (load_dbl) begin
      // digest of the first pass plus fixed padding for a 256-bit message
      for (int i = 0; i < 8; i++) begin
        buf_q[511 - 32*i -: 32] <= h_q[i] + v_q[i];
      end
      buf_q[255:0] <= {PAD_BYTE, 184'd0, 64'd256};
    end else if (shift_en) begin
      buf_q <= {buf_q[503:0], shift_byte};
    end else if (state_q == ST_COMP) begin
      buf_q <= {buf_q[479:0], w_new};
    end
    if (start_comp) begin
      for (int i = 0; i < 8; i++) v_q[i] <= load_dbl ? INIT_H[i] : h_q[i];
    end else if (state_q == ST_COMP) begin
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
    end
  end

endmodule
`default_nettype wire

### rtl/sha256_checker.sv
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sha256_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_ready_o,
  input wire        out_valid_o,
  input wire        out_ready_i,
  input wire [31:0] digest_word_o,
  input wire [2:0]  word_index_o,
  input wire        last_word_o
);
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(digest_word_o))
  `ASSERT_ALWAYS(a_no_overlap, clk_i, !(in_ready_o && out_valid_o))
  `ASSERT_CLK(a_last_idx, clk_i, rst_ni,
    out_valid_o |-> (last_word_o == (word_index_o == 3'd7)))
  `ASSERT_CLK(a_idx_step, clk_i, rst_ni,
    out_valid_o && out_ready_i && !last_word_o |=>
      out_valid_o && word_index_o == $past(word_index_o) + 3'd1)
endmodule

bind sha256_stream_hasher_top sha256_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .digest_word_o(digest_word_o),
  .word_index_o (word_index_o),
  .last_word_o  (last_word_o)
);
`default_nettype wire
